### src/idiv_pkg.sv
// ----------------------------------------------------------------------------
// idiv_pkg
// Shared types and codes for the pipelined integer divider.
// ----------------------------------------------------------------------------
package idiv_pkg;

    localparam int FIELD_W = 64;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_UDIV = 2'd0;
    localparam logic [OP_W-1:0] OP_SDIV = 2'd1;
    localparam logic [OP_W-1:0] OP_UREM = 2'd2;

    // Per-item control carried alongside the datapath through the operand stage and every cell.
    typedef struct packed {
        logic neg_q;    // negate the quotient at the end
        logic rem_sel;  // deliver the remainder instead of the quotient
        logic dz;       // divisor was zero
    } t_ctl;

endpackage

### src/idiv_req_if.sv
// ----------------------------------------------------------------------------
// idiv_req_if
// Request channel: operation code, dividend and divisor with valid/ready.
// ----------------------------------------------------------------------------
interface idiv_req_if;

    logic                               valid;
    logic                               ready;
    logic [idiv_pkg::OP_W-1:0]          req_type;
    logic [idiv_pkg::FIELD_W-1:0]       dividend;
    logic [idiv_pkg::FIELD_W-1:0]       divisor;

    modport source (output valid, output req_type, output dividend, output divisor,
                    input ready);
    modport sink   (input valid, input req_type, input dividend, input divisor,
                    output ready);

endinterface

### src/idiv_rsp_if.sv
// ----------------------------------------------------------------------------
// idiv_rsp_if
// Response channel: result word and divide-by-zero flag with valid/ready.
// ----------------------------------------------------------------------------
interface idiv_rsp_if;

    logic                               valid;
    logic                               ready;
    logic [idiv_pkg::FIELD_W-1:0]       result;
    logic                               div_by_zero;

    modport source (output valid, output result, output div_by_zero, input ready);
    modport sink   (input valid, input result, input div_by_zero, output ready);

endinterface

### src/int64_divider_signed_unsigned.sv
// ----------------------------------------------------------------------------
// int64_divider_signed_unsigned
// Pipelined restoring divider: unsigned/signed quotient or unsigned remainder.
//
//   channel   direction   payload                          transfer when
//   i_req     in          req_type, dividend, divisor      valid && ready
//   o_rsp     out         result, div_by_zero              valid && ready
//
// One item enters per cycle while the pipeline is not stalled; the stages are
// an operand stage (sign strip), one cell per quotient bit, and a result
// stage (sign restore, zero-divisor masking).
// Synchronous active-low reset clears only the stage valid bits.
// Each stage holds while its successor is full and stalled, so bubbles close
// up behind a waiting result.
// ----------------------------------------------------------------------------
module int64_divider_signed_unsigned #(
    parameter int DATA_WIDTH = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    idiv_req_if.sink   i_req,
    idiv_rsp_if.source o_rsp
);

    localparam int W  = DATA_WIDTH;
    localparam int FW = idiv_pkg::FIELD_W;

    // ---------------- operand stage ----------------
    logic           r_valid0;
    logic [W-1:0]   r_rem0;
    logic [W-1:0]   r_quo0;
    logic [W-1:0]   r_den0;
    idiv_pkg::t_ctl r_ctl0;

    logic [W-1:0]   num;
    logic [W-1:0]   den;
    logic           sdiv;
    logic           nneg;
    logic           dneg;
    logic [W-1:0]   n_num;
    logic [W-1:0]   n_den;
    idiv_pkg::t_ctl n_ctl;

    logic           s_ready [0:W];

    always_comb begin
        num   = i_req.dividend[W-1:0];
        den   = i_req.divisor[W-1:0];
        sdiv  = (i_req.req_type == idiv_pkg::OP_SDIV);
        nneg  = sdiv & num[W-1];
        dneg  = sdiv & den[W-1];
        n_num = nneg ? (~num + W'(1)) : num;
        n_den = dneg ? (~den + W'(1)) : den;
        n_ctl.neg_q   = nneg ^ dneg;
        n_ctl.rem_sel = i_req.req_type[1];
        n_ctl.dz      = (den == '0);
    end

    assign i_req.ready = ~r_valid0 | s_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (i_req.ready) begin
            r_valid0 <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_rem0 <= '0;
            r_quo0 <= n_num;
            r_den0 <= n_den;
            r_ctl0 <= n_ctl;
        end
    end

    // ---------------- cell chain ----------------
    logic           s_valid [0:W];
    logic [W-1:0]   s_rem   [0:W];
    logic [W-1:0]   s_quo   [0:W];
    logic [W-1:0]   s_den   [0:W];
    idiv_pkg::t_ctl s_ctl   [0:W];

    assign s_valid[0] = r_valid0;
    assign s_rem[0]   = r_rem0;
    assign s_quo[0]   = r_quo0;
    assign s_den[0]   = r_den0;
    assign s_ctl[0]   = r_ctl0;

    for (genvar k = 0; k < W; k++) begin : g_cell
        idiv_cell #(
            .DATA_WIDTH (W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_rem   (s_rem[k]),
            .i_quo   (s_quo[k]),
            .i_den   (s_den[k]),
            .i_ctl   (s_ctl[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_quo   (s_quo[k+1]),
            .o_den   (s_den[k+1]),
            .o_ctl   (s_ctl[k+1])
        );
    end

    // ---------------- result stage ----------------
    logic         r_out_valid;
    logic [W-1:0] r_res;
    logic         r_dz;
    logic [W-1:0] pick;
    logic [W-1:0] n_res;

    always_comb begin
        pick  = s_ctl[W].rem_sel ? s_rem[W] : s_quo[W];
        n_res = (s_ctl[W].neg_q && !s_ctl[W].rem_sel) ? (~pick + W'(1)) : pick;
        if (s_ctl[W].dz) begin
            n_res = '0;
        end
    end

    assign s_ready[W] = ~r_out_valid | o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_ready[W]) begin
            r_out_valid <= s_valid[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready[W] && s_valid[W]) begin
            r_res <= n_res;
            r_dz  <= s_ctl[W].dz;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result      = FW'(r_res);
    assign o_rsp.div_by_zero = r_dz;

`ifndef SYNTH
    // A zero divisor always yields a zero result word.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.div_by_zero) |-> (o_rsp.result == '0))
        else $error("zero divisor gave non-zero result");

    // A waiting result is not dropped or overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_res)))
        else $error("stalled result changed");

    // A stalled operand stage keeps its divisor until it moves on.
    a_op_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid0 && !s_ready[0]) |=> (r_valid0 && $stable(r_den0)))
        else $error("operand stage lost its item");

    // The operand stage never accepts while it is full and blocked.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid0 && !s_ready[0]) |-> !i_req.ready)
        else $error("request taken into a blocked stage");
`endif

endmodule

### src/idiv_cell.sv
// ----------------------------------------------------------------------------
// idiv_cell
// One restoring shift-subtract step: brings in the next dividend bit,
// trial-subtracts the divisor and registers remainder, quotient and control.
// ----------------------------------------------------------------------------
module idiv_cell #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [DATA_WIDTH-1:0] i_rem,
    input  logic [DATA_WIDTH-1:0] i_quo,
    input  logic [DATA_WIDTH-1:0] i_den,
    input  idiv_pkg::t_ctl        i_ctl,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_WIDTH-1:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_quo,
    output logic [DATA_WIDTH-1:0] o_den,
    output idiv_pkg::t_ctl        o_ctl
);

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_den;
    idiv_pkg::t_ctl        r_ctl;

    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_quo;

    // Partial remainder stays below the divisor, so the shifted value fits
    // in one extra bit and a failed trial leaves it within DATA_WIDTH bits.
    always_comb begin
        trial = {i_rem, i_quo[DATA_WIDTH-1]};
        diff  = trial - {1'b0, i_den};
        ge    = ~diff[DATA_WIDTH];
        n_rem = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        n_quo = {i_quo[DATA_WIDTH-2:0], ge};
    end

    assign o_ready = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_den <= i_den;
            r_ctl <= i_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_den   = r_den;
    assign o_ctl   = r_ctl;

endmodule
